FILE: design/wmcs_pkg.sv
// Package for weighted_moment_cluster_stats: widths and the pi constant.
// No dependencies.
`default_nettype none
package wmcs_pkg;
  localparam int FracBitsDef = 16;
  localparam int SumWidthDef = 48;
  localparam int EnergyW     = 32;
  localparam int TrackW      = 16;
  localparam int MeanW       = 32;
  localparam int StdW        = 31;
  localparam int NumMom      = 4;
  localparam longint unsigned PiQ32 = 64'd13493037705;
endpackage
`default_nettype wire

FILE: design/wmcs_div_cell.sv
// One cell of the restoring divider row: settles one quotient bit per item.
// Depends on nothing but its parameters.
`default_nettype none
module wmcs_div_cell #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int BIT = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] rem_in,
  input  wire logic [NW-1:0] quo_in,
  input  wire logic [DW-1:0] den_in,
  output logic      [NW-1:0] rem_out,
  output logic      [NW-1:0] quo_out,
  output logic      [DW-1:0] den_out
);
  logic [NW+DW-1:0] shifted_den;
  logic             fits;

  always_comb begin
    shifted_den = {{NW{1'b0}}, den_in} << BIT;
    fits = (den_in != '0) && ({{DW{1'b0}}, rem_in} >= shifted_den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= fits ? rem_in - shifted_den[NW-1:0] : rem_in;
      quo_out <= quo_in | (NW'(fits) << BIT);
      den_out <= den_in;
    end
  end
endmodule
`default_nettype wire

FILE: design/wmcs_sqrt_cell.sv
// One cell of the square root row: one result bit per item.
// Depends on nothing but its parameters.
`default_nettype none
module wmcs_sqrt_cell #(
  parameter int VW = 64,
  parameter int BIT = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [VW-1:0] rem_in,
  input  wire logic [VW/2-1:0] root_in,
  output logic      [VW-1:0] rem_out,
  output logic      [VW/2-1:0] root_out
);
  logic [VW/2-1:0] trial;
  logic [VW+1:0]   sq;

  always_comb begin
    trial = root_in | (VW/2)'(1'b1) << BIT;
    sq = (VW+2)'(trial) * (VW+2)'(trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_in;
      root_out <= (sq <= (VW+2)'(rem_in)) ? trial : root_in;
    end
  end
endmodule
`default_nettype wire

FILE: design/wmcs_moment.sv
// Mean and spread of one weighted pair: divider rows, variance, root row.
// Depends on wmcs_div_cell and wmcs_sqrt_cell.
`default_nettype none
module wmcs_moment #(
  parameter int SW = 48
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [SW-1:0]     sum_in,
  input  wire logic [SW-1:0]     sq_in,
  input  wire logic [31:0]       energy,
  output logic signed [SW:0]     mean,
  output logic      [31:0]       spread
);
  localparam int DEPTH = SW + 2 + 32;

  logic [SW-1:0] r_rem [SW+1];
  logic [SW-1:0] r_quo [SW+1];
  logic [31:0]   r_den [SW+1];
  logic [SW-1:0] s_rem [SW+1];
  logic [SW-1:0] s_quo [SW+1];
  logic [31:0]   s_den [SW+1];
  logic          neg_line [SW+1];
  logic          neg_d;
  logic [SW-1:0] q_d;
  logic [63:0]   var_d;

  logic [63:0]   v_rem [33];
  logic [31:0]   v_root [33];
  logic signed [SW:0] m_line [33];

  always_comb begin
    r_rem[0] = sum_in[SW-1] ? SW'(0) - sum_in : sum_in;
    r_quo[0] = '0;
    r_den[0] = energy;
    s_rem[0] = sq_in;
    s_quo[0] = '0;
    s_den[0] = energy;
    neg_line[0] = sum_in[SW-1];
  end

  for (genvar i = 0; i < SW; i++) begin : g_div
    wmcs_div_cell #(.NW(SW), .DW(32), .BIT(SW-1-i)) u_m (
      .clk, .en, .rem_in(r_rem[i]), .quo_in(r_quo[i]), .den_in(r_den[i]),
      .rem_out(r_rem[i+1]), .quo_out(r_quo[i+1]), .den_out(r_den[i+1]));
    wmcs_div_cell #(.NW(SW), .DW(32), .BIT(SW-1-i)) u_s (
      .clk, .en, .rem_in(s_rem[i]), .quo_in(s_quo[i]), .den_in(s_den[i]),
      .rem_out(s_rem[i+1]), .quo_out(s_quo[i+1]), .den_out(s_den[i+1]));
    always_ff @(posedge clk) if (en) neg_line[i+1] <= neg_line[i];
  end

  // Register q before squaring so the multiplier stands alone
  logic [SW-1:0] sq_d;
  always_ff @(posedge clk) begin
    if (en) begin
      q_d <= r_quo[SW];
      sq_d <= s_quo[SW];
      neg_d <= neg_line[SW];
    end
  end

  logic [63:0] q2;
  logic        big;
  always_comb begin
    big = (SW > 32) ? (q_d >> (SW > 32 ? 32 : 0)) != '0 : 1'b0;
    q2  = 64'(q_d[31:0]) * 64'(q_d[31:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      var_d <= (!big && 64'(sq_d) > q2) ? 64'(sq_d) - q2 : 64'd0;
      m_line[0] <= neg_d ? -$signed({1'b0, q_d}) : $signed({1'b0, q_d});
    end
  end

  always_comb begin
    v_rem[0]  = var_d;
    v_root[0] = '0;
  end

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    wmcs_sqrt_cell #(.VW(64), .BIT(31-j)) u_r (
      .clk, .en, .rem_in(v_rem[j]), .root_in(v_root[j]),
      .rem_out(v_rem[j+1]), .root_out(v_root[j+1]));
    always_ff @(posedge clk) if (en) m_line[j+1] <= m_line[j];
  end

  assign mean   = m_line[32];
  assign spread = v_root[32];
  logic unused;
  assign unused = ^{r_rem[SW], s_rem[SW], r_den[SW], s_den[SW], v_rem[32], DEPTH[0]};
endmodule
`default_nettype wire

FILE: design/weighted_moment_cluster_stats.sv
// Top level: four moment pipelines, phi choice, saturation, output register.
// Depends on wmcs_pkg and wmcs_moment.
//
//  channel | signals                                           | dir
//  in      | in_valid/in_stall, cluster_tag, sums, energy      | in
//  out     | out_valid/out_stall, cluster_tag_out, means/stds  | out
//
// One item per cycle while the output is not stalled; the depth is set by the divider row
// (one quotient bit per cell) and the 32-cell root row.
// The whole pipeline advances when the output register is free; a stall
// at the output freezes every stage. Reset clears the valid line only.
// Zero-energy items travel as bubbles and give no result.
`default_nettype none
module weighted_moment_cluster_stats #(
  parameter int FRAC_BITS = wmcs_pkg::FracBitsDef,
  parameter int SUM_WIDTH = wmcs_pkg::SumWidthDef
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [15:0]          cluster_tag,
  input  wire logic [SUM_WIDTH-1:0] phi_sum,
  input  wire logic [SUM_WIDTH-1:0] phi_sq_sum,
  input  wire logic [SUM_WIDTH-1:0] radius_sum,
  input  wire logic [SUM_WIDTH-1:0] radius_sq_sum,
  input  wire logic [SUM_WIDTH-1:0] eta_sum,
  input  wire logic [SUM_WIDTH-1:0] eta_sq_sum,
  input  wire logic [SUM_WIDTH-1:0] rot_phi_sum,
  input  wire logic [SUM_WIDTH-1:0] rot_phi_sq_sum,
  input  wire logic [31:0]          energy_sum,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [15:0]               cluster_tag_out,
  output logic signed [31:0]        phi_centre,
  output logic [30:0]               phi_std,
  output logic signed [31:0]        radius_mean,
  output logic [30:0]               radius_std,
  output logic signed [31:0]        eta_mean,
  output logic [30:0]               eta_std
);
  localparam int LAT = SUM_WIDTH + 34;
  localparam longint unsigned PiFix =
    (wmcs_pkg::PiQ32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

  logic en;
  logic vld [LAT+1];
  logic [15:0] tid [LAT+1];
  logic signed [SUM_WIDTH:0] mean [4];
  logic [31:0] spread [4];
  logic [SUM_WIDTH-1:0] sums [4];
  logic [SUM_WIDTH-1:0] sqs [4];

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  assign sums = '{phi_sum, radius_sum, eta_sum, rot_phi_sum};
  assign sqs  = '{phi_sq_sum, radius_sq_sum, eta_sq_sum, rot_phi_sq_sum};

  for (genvar k = 0; k < 4; k++) begin : g_mom
    wmcs_moment #(.SW(SUM_WIDTH)) u_mom (
      .clk, .en, .sum_in(sums[k]), .sq_in(sqs[k]), .energy(energy_sum),
      .mean(mean[k]), .spread(spread[k]));
  end

  always_comb begin
    vld[0] = in_valid && (energy_sum != '0);
    tid[0] = cluster_tag;
  end

  for (genvar i = 0; i < LAT; i++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) if (en) tid[i+1] <= tid[i];
  end

  function automatic logic [31:0] sat_mean(input logic signed [SUM_WIDTH:0] v);
    if (v > (SUM_WIDTH+1)'(64'sd2147483647)) return 32'h7fffffff;
    else if (v < -(SUM_WIDTH+1)'(64'sd2147483648)) return 32'h80000000;
    else return v[31:0];
  endfunction

  logic use_rot;
  logic signed [SUM_WIDTH:0] pm;
  logic [31:0] ps;
  always_comb begin
    use_rot = spread[0] > spread[3];
    pm = use_rot ? mean[3] : mean[0];
    ps = use_rot ? spread[3] : spread[0];
    if (use_rot && pm > $signed((SUM_WIDTH+1)'(PiFix)))
      pm = pm - $signed((SUM_WIDTH+1)'(2 * PiFix));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cluster_tag_out <= tid[LAT];
      phi_centre      <= sat_mean(pm);
      phi_std         <= ps[31] ? 31'h7fffffff : ps[30:0];
      radius_mean     <= sat_mean(mean[1]);
      radius_std      <= spread[1][31] ? 31'h7fffffff : spread[1][30:0];
      eta_mean        <= sat_mean(mean[2]);
      eta_std         <= spread[2][31] ? 31'h7fffffff : spread[2][30:0];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(phi_centre))
    else $error("result lost under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
endmodule
`default_nettype wire

FILE: tb/tb_weighted_moment_cluster_stats.sv
// Testbench for weighted_moment_cluster_stats: directed and random clusters,
// scoreboard against a local fixed-point model. Depends on wmcs_pkg and the block.
`default_nettype none
module tb_weighted_moment_cluster_stats;

  localparam int FB = wmcs_pkg::FracBitsDef;
  localparam int SW = wmcs_pkg::SumWidthDef;
  localparam int LAT = SW + 35;
  localparam int WDOG = 20000;
  localparam longint PI_FX =
    longint'((wmcs_pkg::PiQ32 + (64'd1 << (31 - FB))) >> (32 - FB));

  typedef struct packed {
    logic [15:0]   tid;
    logic [SW-1:0] ps, pq, rs, rq, es, eq, ts, tq;
    logic [31:0]   en;
  } cluster_t;

  typedef struct packed {
    logic [15:0] tid;
    logic [31:0] pm;
    logic [30:0] pd;
    logic [31:0] rm;
    logic [30:0] rd;
    logic [31:0] em;
    logic [30:0] ed;
  } stats_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [15:0] cluster_tag = 0, cluster_tag_out;
  logic [SW-1:0] phi_sum = 0, phi_sq_sum = 0, radius_sum = 0, radius_sq_sum = 0;
  logic [SW-1:0] eta_sum = 0, eta_sq_sum = 0, rot_phi_sum = 0, rot_phi_sq_sum = 0;
  logic [31:0] energy_sum = 0;
  logic signed [31:0] phi_centre, radius_mean, eta_mean;
  logic [30:0] phi_std, radius_std, eta_std;

  cluster_t pending_q[$];
  stats_t   stats_q[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  n_items = 0;
  bit  calm = 0, hold_off = 0, in_held = 0;

  weighted_moment_cluster_stats u_dut (.*);

  initial forever #4 clk = ~clk;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Mean and spread of one weighted pair; mean kept at full width.
  function automatic void pair_moment(logic [SW-1:0] s, logic [SW-1:0] sq,
                                      logic [31:0] en, output longint mean,
                                      output longint unsigned spread);
    longint unsigned mag, q, d, var_v;
    mag = s[SW-1] ? 64'((~s) + 1'b1) & ((64'd1 << SW) - 1) : 64'(s);
    q = mag / en;
    d = 64'(sq) / en;
    var_v = 0;
    mean = s[SW-1] ? -longint'(q) : longint'(q);
    if (q < (64'd1 << 32) && d > q * q) var_v = d - q * q;
    spread = isqrt(var_v);
  endfunction

  function automatic logic [31:0] clamp_mean(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [30:0] clamp_std(longint unsigned v);
    return v > 64'h7fffffff ? 31'h7fffffff : v[30:0];
  endfunction

  function automatic void predict_stats(cluster_t c);
    longint pm, rm, em, tm;
    longint unsigned pd, rd, ed, td;
    stats_t r;
    if (c.en == 0) return;
    pair_moment(c.ps, c.pq, c.en, pm, pd);
    pair_moment(c.rs, c.rq, c.en, rm, rd);
    pair_moment(c.es, c.eq, c.en, em, ed);
    pair_moment(c.ts, c.tq, c.en, tm, td);
    if (pd > td) begin
      pm = tm;
      pd = td;
      if (pm > PI_FX) pm -= 2 * PI_FX;
    end
    r.tid = c.tid;
    r.pm = clamp_mean(pm); r.pd = clamp_std(pd);
    r.rm = clamp_mean(rm); r.rd = clamp_std(rd);
    r.em = clamp_mean(em); r.ed = clamp_std(ed);
    stats_q.insert(stats_q.size(), r);
  endfunction

  function automatic void queue_item(cluster_t c);
    pending_q.insert(pending_q.size(), c);
  endfunction

  function automatic logic [SW-1:0] rnd_w();
    return SW'({$urandom, $urandom});
  endfunction

  // Consistent cluster: n hits with small energies give a real spread.
  function automatic cluster_t make_cluster(int unsigned spread_lim);
    cluster_t c;
    longint v, e, eh;
    int n;
    c = '0;
    c.tid = 16'($urandom);
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      eh = $urandom_range(1, 4000);
      c.en = c.en + 32'(eh);
      v = longint'($urandom_range(0, 2 * spread_lim)) - spread_lim;
      c.ps = c.ps + SW'(eh * v);  c.pq = c.pq + SW'(eh * v * v);
      v = longint'($urandom_range(0, 2 * spread_lim)) - spread_lim;
      c.rs = c.rs + SW'(eh * v);  c.rq = c.rq + SW'(eh * v * v);
      v = longint'($urandom_range(0, 2 * spread_lim)) - spread_lim;
      c.es = c.es + SW'(eh * v);  c.eq = c.eq + SW'(eh * v * v);
      v = longint'($urandom_range(0, 4 * spread_lim)) - spread_lim;
      c.ts = c.ts + SW'(eh * v);  c.tq = c.tq + SW'(eh * v * v);
    end
    return c;
  endfunction

  function automatic cluster_t noise_cluster();
    cluster_t c;
    c = {16'($urandom), rnd_w(), rnd_w(), rnd_w(), rnd_w(), rnd_w(), rnd_w(),
         rnd_w(), rnd_w(), $urandom};
    case ($urandom_range(0, 3))
      0: c.en = $urandom_range(1, 16);
      1: c.en = 0;
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    cluster_t c;
    logic [SW-1:0] smax, smin;
    smax = {1'b0, {(SW-1){1'b1}}};
    smin = {1'b1, {(SW-1){1'b0}}};
    // zero energy, extremes, negative variance, equal spreads, wrap above pi
    c = '1; c.en = 0; queue_item(c);
    c = '0; c.en = 1; queue_item(c);
    c = '1; queue_item(c);
    c = '0; c.tid = '1; c.en = 1; c.ps = smax; c.rs = smin; c.es = smax; c.ts = smin;
    c.pq = '1; c.rq = '1; c.eq = '1; c.tq = '1; queue_item(c);
    c.en = '1; queue_item(c);
    c = '0; c.en = 4; c.ps = SW'(400); c.pq = '0; c.rs = smin; c.es = SW'(-40);
    queue_item(c);
    c = '0; c.en = 2; c.ps = SW'(100); c.pq = SW'(5200); c.ts = SW'(100);
    c.tq = SW'(5200);
    queue_item(c);
    c = '0; c.en = 1; c.ps = '0; c.pq = SW'(64'd1 << 40); c.ts = SW'(PI_FX + 1);
    c.tq = '0;
    queue_item(c);
    c.ts = SW'(PI_FX); queue_item(c);
    c.ts = SW'(3 * PI_FX); queue_item(c);
    c.ts = SW'(-PI_FX * 3); queue_item(c);
    c = '0; c.en = 3; c.ps = smax; c.pq = '0; queue_item(c);
    c.ps = smin; queue_item(c);
    repeat (6) queue_item(noise_cluster());
    for (int i = 0; i < 1250; i++) begin
      if (i == 400) begin
        c = '0; c.en = 0; c.tid = 16'h5a5a; queue_item(c);
      end
      if ($urandom_range(0, 9) < 8)
        queue_item(make_cluster($urandom_range(0, 9) < 7 ? 200000 : 30000000));
      else
        queue_item(noise_cluster());
    end
    n_items = pending_q.size();
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 0;
  end

  // Driver: one item per handshake, idles at random except in the calm stretch.
  int sent = 0;
  always @(negedge clk) begin
    calm <= (sent > 600 && sent < 800);
    if (!rst) begin
      if (in_held) begin
        // hold the stalled item
      end else if (sent == 500 && !hold_off && stats_q.size() != 0) begin
        in_valid <= 0;
      end else if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
        c_drive(pending_q.pop_front());
      end else begin
        in_valid <= 0;
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 32);
    end
  end

  task automatic c_drive(cluster_t c);
    in_valid <= 1;
    cluster_tag <= c.tid;
    phi_sum <= c.ps;  phi_sq_sum <= c.pq;
    radius_sum <= c.rs;  radius_sq_sum <= c.rq;
    eta_sum <= c.es;  eta_sq_sum <= c.eq;
    rot_phi_sum <= c.ts;  rot_phi_sq_sum <= c.tq;
    energy_sum <= c.en;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %h actual %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: model on accepted input, compare on accepted output.
  always @(posedge clk) begin
    stats_t e;
    cluster_t c;
    in_held <= in_valid && in_stall;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        c = {cluster_tag, phi_sum, phi_sq_sum, radius_sum, radius_sq_sum, eta_sum,
             eta_sq_sum, rot_phi_sum, rot_phi_sq_sum, energy_sum};
        predict_stats(c);
        sent <= sent + 1;
        if (sent == 500) hold_off <= 1;
      end
      if (out_valid && !out_stall) begin
        if (stats_q.size() == 0) begin
          $error("result with nothing expected, cluster_tag_out %h", cluster_tag_out);
          errors++;
        end else begin
          e = stats_q.pop_front();
          check_field("cluster_tag_out", e.tid, cluster_tag_out);
          check_field("phi_centre", e.pm, phi_centre);
          check_field("phi_std", e.pd, phi_std);
          check_field("radius_mean", e.rm, radius_mean);
          check_field("radius_std", e.rd, radius_std);
          check_field("eta_mean", e.em, eta_mean);
          check_field("eta_std", e.ed, eta_std);
        end
      end
    end
  end

  initial begin
    wait (!rst);
    fork
      begin
        wait (n_items != 0 && sent == n_items);
        wait (stats_q.size() == 0);
        repeat (4 * LAT) @(posedge clk);
      end
      wait (idle_cycles >= WDOG);
    join_any
    if (idle_cycles >= WDOG) begin
      $display("tb_weighted_moment_cluster_stats: errors");
    end else if (errors == 0 && stats_q.size() == 0) begin
      $display("tb_weighted_moment_cluster_stats: clean");
    end else begin
      $display("tb_weighted_moment_cluster_stats: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: weighted_moment_cluster_stats.f
design/wmcs_pkg.sv
design/wmcs_div_cell.sv
design/wmcs_sqrt_cell.sv
design/wmcs_moment.sv
design/weighted_moment_cluster_stats.sv
tb/tb_weighted_moment_cluster_stats.sv
